>>> rtl/lrz_pkg.sv
// Package for the antialiased line rasterizer: widths, coverage constants and control structs.
`default_nettype none

package lrz_pkg;

    // Widths of the transfer fields
    localparam int COORD_W = 5;
    localparam int PIX_W   = 6;
    localparam int COV_W   = 9;

    // Defaults of the top-level parameters
    localparam int COORD_BITS_DEF = 5;
    localparam int FRAC_BITS_DEF  = 16;

    // Coverage levels in units of 1/256
    localparam logic [COV_W-1:0] COV_FULL = 9'd256;
    localparam logic [COV_W-1:0] COV_HALF = 9'd128;
    localparam logic [COV_W-1:0] COV_NONE = 9'd0;

    // Number of leading results that belong to the two endpoints
    localparam int ENDPOINT_RESULTS = 4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic prep;
        logic emit;
    } lrz_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic degenerate;
        logic slot_free;
        logic last;
    } lrz_stat_t;

endpackage

`default_nettype wire

>>> rtl/lrz_seg_if.sv
// Interfaces of the rasterizer: segment channel and pixel channel.
`default_nettype none

interface lrz_seg_if import lrz_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

interface lrz_pix_if import lrz_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [COV_W-1:0] coverage;
    logic             last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output coverage,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input coverage,
                    input last_pixel, output ready);
endinterface

`default_nettype wire

>>> rtl/lrz_ctrl.sv
// Controller of the rasterizer: sequences setup, gradient division and pixel emission.
`default_nettype none

module lrz_ctrl import lrz_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire lrz_stat_t stat,
    output lrz_cmd_t       cmd
);

    localparam int NUM_STEPS  = COORD_BITS + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(NUM_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PREP,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic                   in_ready_reg, in_ready_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    // Commands follow the current state; a segment is loaded on a transfer
    always_comb
    begin
        cmd          = '0;
        cmd.load     = (state_reg == ST_IDLE) && in_valid && in_ready_reg;
        cmd.div_step = (state_reg == ST_DIVIDE);
        cmd.prep     = (state_reg == ST_PREP);
        cmd.emit     = (state_reg == ST_EMIT) && stat.slot_free;
    end

    // Next state, ready flag and division step counter
    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        div_cnt_next  = div_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    in_ready_next = 1'b0;
                    div_cnt_next  = '0;
                    // A single point needs no gradient
                    state_next    = stat.degenerate ? ST_EMIT : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(NUM_STEPS - 1))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (cmd.emit && stat.last)
                begin
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

`default_nettype wire

>>> rtl/lrz_dp.sv
// Datapath of the rasterizer: segment setup, serial gradient divider, accumulator and output register.
`default_nettype none

module lrz_dp import lrz_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lrz_cmd_t           cmd,
    output lrz_stat_t               stat,
    input  wire logic [COORD_W-1:0] start_x,
    input  wire logic [COORD_W-1:0] start_y,
    input  wire logic [COORD_W-1:0] end_x,
    input  wire logic [COORD_W-1:0] end_y,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [PIX_W-1:0]        pixel_x,
    output logic [PIX_W-1:0]        pixel_y,
    output logic [COV_W-1:0]        coverage,
    output logic                    last_pixel
);

    localparam int CB    = COORD_BITS;
    localparam int MW    = COORD_BITS + 1;
    localparam int NUM   = COORD_BITS + FRAC_BITS;
    localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
    localparam int CNT_W = COORD_BITS + 1;

    // Segment registers
    logic              steep_reg, neg_reg, deg_reg;
    logic [CB-1:0]     x1_reg, y1_reg, x2_reg, y2_reg, d_reg, xcur_reg;
    logic [CB-1:0]     rem_reg;
    logic [NUM-1:0]    quo_reg;
    logic [ACC_W-1:0]  grad_reg, acc_reg;
    logic [CNT_W-1:0]  k_reg;

    // Output register
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_x_reg, out_y_reg;
    logic [COV_W-1:0]  out_cov_reg;
    logic              out_last_reg;

    // Setup signals
    logic [CB-1:0]     ax1, ay1, ax2, ay2, adx, ady;
    logic [CB-1:0]     sx1, sy1, sx2, sy2, mx1, my1, mx2, my2, d_w, mag_w;
    logic              steep_w, swap_w, neg_w, deg_w;

    // Divider signals
    logic [CB:0]       div_shift;
    logic              div_fits;
    logic [CB:0]       div_diff;

    // Emission signals
    logic [ACC_W-1:0]  grad_w;
    logic              interior, odd_half;
    logic [MW-1:0]     ip, minor;
    logic [CB-1:0]     major;
    logic [COV_W-1:0]  upper, cov;
    logic              last_w;

    // Mask the coordinates, pick the major axis and order the endpoints
    always_comb
    begin
        ax1     = start_x[CB-1:0];
        ay1     = start_y[CB-1:0];
        ax2     = end_x[CB-1:0];
        ay2     = end_y[CB-1:0];
        adx     = (ax2 > ax1) ? ax2 - ax1 : ax1 - ax2;
        ady     = (ay2 > ay1) ? ay2 - ay1 : ay1 - ay2;
        steep_w = ady > adx;
        sx1     = steep_w ? ay1 : ax1;
        sy1     = steep_w ? ax1 : ay1;
        sx2     = steep_w ? ay2 : ax2;
        sy2     = steep_w ? ax2 : ay2;
        swap_w  = sx1 > sx2;
        mx1     = swap_w ? sx2 : sx1;
        my1     = swap_w ? sy2 : sy1;
        mx2     = swap_w ? sx1 : sx2;
        my2     = swap_w ? sy1 : sy2;
        d_w     = mx2 - mx1;
        neg_w   = my2 < my1;
        mag_w   = neg_w ? my1 - my2 : my2 - my1;
        deg_w   = (ax1 == ax2) && (ay1 == ay2);
    end

    // One restoring division step: one quotient bit per cycle
    always_comb
    begin
        div_shift = {rem_reg, quo_reg[NUM-1]};
        div_fits  = div_shift >= {1'b0, d_reg};
        div_diff  = div_shift - {1'b0, d_reg};
    end

    // Signed gradient from the quotient magnitude
    always_comb
    begin
        grad_w = ACC_W'(quo_reg[FRAC_BITS:0]);
        if (neg_reg)
        begin
            grad_w = ACC_W'(~grad_w + 1'b1);
        end
    end

    // Select the pixel of the current result
    always_comb
    begin
        interior = k_reg >= CNT_W'(ENDPOINT_RESULTS);
        odd_half = k_reg[0];
        ip       = acc_reg[ACC_W-1:FRAC_BITS];
        upper    = COV_W'(acc_reg[FRAC_BITS-1 -: 8]);
        priority if (deg_reg)
        begin
            major = x1_reg;
            minor = MW'(y1_reg);
            cov   = COV_FULL;
        end
        else if (!interior)
        begin
            major = k_reg[1] ? x2_reg : x1_reg;
            minor = MW'(k_reg[1] ? y2_reg : y1_reg) + MW'(odd_half);
            cov   = odd_half ? COV_NONE : COV_HALF;
        end
        else
        begin
            major = xcur_reg;
            minor = ip + MW'(odd_half);
            cov   = odd_half ? upper : COV_FULL - upper;
        end
        last_w = deg_reg || (k_reg == {d_reg, 1'b1});
    end

    // Segment, divider and accumulator registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            steep_reg <= steep_w;
            neg_reg   <= neg_w;
            deg_reg   <= deg_w;
            x1_reg    <= mx1;
            y1_reg    <= my1;
            x2_reg    <= mx2;
            y2_reg    <= my2;
            d_reg     <= d_w;
            xcur_reg  <= mx1 + 1'b1;
            k_reg     <= '0;
            rem_reg   <= '0;
            quo_reg   <= {mag_w, {FRAC_BITS{1'b0}}};
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_fits ? div_diff[CB-1:0] : div_shift[CB-1:0];
            quo_reg <= {quo_reg[NUM-2:0], div_fits};
        end
        if (cmd.prep)
        begin
            grad_reg <= grad_w;
            acc_reg  <= ACC_W'({y1_reg, {FRAC_BITS{1'b0}}}) + grad_w;
        end
        if (cmd.emit)
        begin
            k_reg <= k_reg + 1'b1;
            if (interior && odd_half)
            begin
                acc_reg  <= acc_reg + grad_reg;
                xcur_reg <= xcur_reg + 1'b1;
            end
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_x_reg    <= steep_reg ? PIX_W'(minor) : PIX_W'(major);
            out_y_reg    <= steep_reg ? PIX_W'(major) : PIX_W'(minor);
            out_cov_reg  <= cov;
            out_last_reg <= last_w;
        end
    end

    // Output valid: set by a new result, cleared by a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        stat.degenerate = deg_w;
        stat.slot_free  = !out_valid_reg || out_ready;
        stat.last       = last_w;
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = out_x_reg;
    assign pixel_y    = out_y_reg;
    assign coverage   = out_cov_reg;
    assign last_pixel = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/antialiased_line_rasterizer.sv
// Top level of the antialiased line rasterizer: controller and datapath on two channels.
//
//   channel  modport  payload                                   role
//   seg      sink     start_x, start_y, end_x, end_y            one segment per transfer
//   pix      source   pixel_x, pixel_y, coverage, last_pixel    one pixel per transfer
//
// A segment is loaded, then a serial division yields COORD_BITS + FRAC_BITS quotient bits
// (one quotient bit per cycle), the accumulator is set up, and pixels follow at one per
// cycle while the pixel channel does not stall: 2*d + 2 pixels for a major length d.
// A single point skips the division and the accumulator setup and gives one pixel.
// Reset clears the controller and the output valid flag; the block is ready at once.
// A stalled pixel channel holds the result in the output register and halts emission.
`default_nettype none

module antialiased_line_rasterizer import lrz_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lrz_seg_if.sink    seg,
    lrz_pix_if.source  pix
);

    lrz_cmd_t  cmd;
    lrz_stat_t stat;

    lrz_ctrl #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (seg.valid),
        .in_ready (seg.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrz_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .start_x    (seg.start_x),
        .start_y    (seg.start_y),
        .end_x      (seg.end_x),
        .end_y      (seg.end_y),
        .out_valid  (pix.valid),
        .out_ready  (pix.ready),
        .pixel_x    (pix.pixel_x),
        .pixel_y    (pix.pixel_y),
        .coverage   (pix.coverage),
        .last_pixel (pix.last_pixel)
    );

endmodule

`default_nettype wire

>>> tb/sv/antialiased_line_rasterizer_tb.sv
// Testbench for the antialiased line rasterizer: directed and random segments against a Wu line predictor.
`timescale 1ns / 100ps

module antialiased_line_rasterizer_tb;
    import lrz_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int COORD_MAX   = (1 << COORD_BITS_DEF) - 1;
    localparam int IDLE_LIMIT  = 4000;
    localparam int END_CYCLES  = 200;
    localparam int RANDOM_SEGS = 160;

    typedef struct packed {
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } segment_t;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic [COV_W-1:0] cov;
        logic             last;
    } pixel_t;

    logic clk;
    logic rst_n;

    lrz_seg_if seg ();
    lrz_pix_if pix ();

    antialiased_line_rasterizer dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg.sink),
        .pix   (pix.source)
    );

    // Pixels still owed by the block, oldest first.
    pixel_t expected_pixels[$];
    int     mismatch_count = 0;
    int     idle_cycles    = 0;

    // Sender burst control.
    bit     sender_gaps_on = 1'b1;
    int     burst_left     = 0;

    // Receiver stall pattern.
    int     stall_mode     = 0;
    int     stall_left     = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Append one expected pixel, mapping major and minor back onto x and y.
    function automatic void add_pixel(bit steep, longint unsigned major,
                                      longint unsigned minor, logic [COV_W-1:0] cov);
        pixel_t p;
        p.x    = PIX_W'(steep ? minor : major);
        p.y    = PIX_W'(steep ? major : minor);
        p.cov  = cov;
        p.last = 1'b0;
        expected_pixels.push_back(p);
    endfunction

    // Work out the whole pixel burst that one segment should produce.
    function automatic void predict_segment(segment_t s);
        longint unsigned a1, b1, a2, b2, swap_tmp, span, rise;
        longint unsigned slope_mag, slope, acc, ip, upper;
        longint unsigned fmask;
        bit steep, falling;
        a1    = s.sx;
        b1    = s.sy;
        a2    = s.ex;
        b2    = s.ey;
        fmask = (longint'(1) << FRAC) - 1;
        if (a1 == a2 && b1 == b2)
        begin
            // A single point is drawn at full intensity.
            add_pixel(1'b0, a1, b1, COV_FULL);
        end
        else
        begin
            steep = ((b2 > b1) ? b2 - b1 : b1 - b2) > ((a2 > a1) ? a2 - a1 : a1 - a2);
            if (steep)
            begin
                swap_tmp = a1; a1 = b1; b1 = swap_tmp;
                swap_tmp = a2; a2 = b2; b2 = swap_tmp;
            end
            if (a1 > a2)
            begin
                swap_tmp = a1; a1 = a2; a2 = swap_tmp;
                swap_tmp = b1; b1 = b2; b2 = swap_tmp;
            end
            span      = a2 - a1;
            falling   = b2 < b1;
            rise      = falling ? b1 - b2 : b2 - b1;
            slope_mag = (rise << FRAC) / span;
            slope     = falling ? -slope_mag : slope_mag;

            // Both endpoints first, each as a half-covered pixel and an empty neighbour.
            add_pixel(steep, a1, b1, COV_HALF);
            add_pixel(steep, a1, b1 + 1, COV_NONE);
            add_pixel(steep, a2, b2, COV_HALF);
            add_pixel(steep, a2, b2 + 1, COV_NONE);

            // Interior columns from the fixed-point minor accumulator.
            acc = (b1 << FRAC) + slope;
            for (longint unsigned m = a1 + 1; m < a2; m++)
            begin
                ip    = acc >> FRAC;
                upper = (acc & fmask) >> (FRAC - 8);
                add_pixel(steep, m, ip, COV_FULL - COV_W'(upper));
                add_pixel(steep, m, ip + 1, COV_W'(upper));
                acc   = acc + slope;
            end
        end
        expected_pixels[expected_pixels.size() - 1].last = 1'b1;
    endfunction

    // Compare one field and report any difference.
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Hold the segment channel idle for a number of cycles.
    task automatic seg_idle(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            seg.valid <= 1'b0;
        end
    endtask

    // Offer one segment, wait for its transfer, then perhaps leave a gap.
    task automatic send_segment(segment_t s);
        @(negedge clk);
        seg.valid   <= 1'b1;
        seg.start_x <= s.sx;
        seg.start_y <= s.sy;
        seg.end_x   <= s.ex;
        seg.end_y   <= s.ey;
        do
            @(posedge clk);
        while (!seg.ready);
        predict_segment(s);
        if (sender_gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 7);
                seg_idle($urandom_range(1, 12));
            end
        end
    endtask

    // Stop offering segments until every owed pixel has arrived.
    task automatic wait_drained();
        seg_idle(1);
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    function automatic segment_t make_segment(int sx, int sy, int ex, int ey);
        segment_t s;
        s.sx = COORD_W'(sx);
        s.sy = COORD_W'(sy);
        s.ex = COORD_W'(ex);
        s.ey = COORD_W'(ey);
        return s;
    endfunction

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    // Single points, including both corners of the tile.
    task automatic test_degenerate();
        send_segment(make_segment(0, 0, 0, 0));
        send_segment(make_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_segment(make_segment(5, 17, 5, 17));
    endtask

    // Shallow lines: flat, reversed, rising and falling, diagonal and the shortest.
    task automatic test_shallow();
        send_segment(make_segment(0, 0, COORD_MAX, 0));
        send_segment(make_segment(COORD_MAX, COORD_MAX, 0, COORD_MAX));
        send_segment(make_segment(0, COORD_MAX, COORD_MAX, 0));
        send_segment(make_segment(0, 0, COORD_MAX, COORD_MAX));
        send_segment(make_segment(COORD_MAX, 0, 0, COORD_MAX));
        send_segment(make_segment(3, 4, 4, 4));
        send_segment(make_segment(20, 9, 1, 16));
    endtask

    // Steep lines: vertical, nearly vertical in both directions and the shortest.
    task automatic test_steep();
        send_segment(make_segment(0, 0, 0, COORD_MAX));
        send_segment(make_segment(COORD_MAX, COORD_MAX, COORD_MAX, 0));
        send_segment(make_segment(COORD_MAX, 0, COORD_MAX - 1, COORD_MAX));
        send_segment(make_segment(10, 2, 4, 29));
        send_segment(make_segment(7, 7, 7, 8));
        send_segment(make_segment(0, COORD_MAX, 1, 0));
    endtask

    // Random segments of mixed kinds, with stretches of back-to-back transfers.
    task automatic test_random_segments();
        int sx, sy, ex, ey, kind;
        for (int i = 0; i < RANDOM_SEGS; i++)
        begin
            if (i % 40 == 0)
                sender_gaps_on = $urandom_range(0, 2) != 0;
            if (i % 50 == 25)
                wait_drained();
            sx   = $urandom_range(0, COORD_MAX);
            sy   = $urandom_range(0, COORD_MAX);
            ex   = $urandom_range(0, COORD_MAX);
            ey   = $urandom_range(0, COORD_MAX);
            kind = $urandom_range(0, 9);
            case (kind)
                0:
                begin
                    ex = sx;
                    ey = sy;
                end
                1, 2:
                begin
                    ex = clamp_coord(sx + $urandom_range(0, 6) - 3);
                    ey = clamp_coord(sy + $urandom_range(0, 6) - 3);
                end
                3:
                begin
                    if ($urandom_range(0, 1))
                        ey = sy;
                    else
                        ex = sx;
                end
                4:
                begin
                    ey = ($urandom_range(0, 1)) ? clamp_coord(sy + (ex - sx))
                                                : clamp_coord(sy - (ex - sx));
                end
                default:
                begin
                end
            endcase
            send_segment(make_segment(sx, sy, ex, ey));
        end
        sender_gaps_on = 1'b1;
    endtask

    // Check every pixel transfer against the oldest expectation.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix.valid && pix.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d cov=%0d last=%0d",
                         $time, pix.pixel_x, pix.pixel_y, pix.coverage, pix.last_pixel);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("pixel_x", want.x, pix.pixel_x);
                check_field("pixel_y", want.y, pix.pixel_y);
                check_field("coverage", want.cov, pix.coverage);
                check_field("last_pixel", want.last, pix.last_pixel);
            end
        end
    end

    // Receiver stalls on a pattern that changes mode every so often.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 120);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       pix.ready <= 1'b1;
            1:       pix.ready <= 1'($urandom_range(0, 1));
            2:       pix.ready <= ($urandom_range(0, 3) == 0);
            default: pix.ready <= stall_left[3];
        endcase
    end

    // Watchdog: ends the run if no transfer happens on either channel for too long.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((seg.valid && seg.ready) || (pix.valid && pix.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("** antialiased_line_rasterizer: FAILED **");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n       = 1'b0;
        seg.valid   = 1'b0;
        seg.start_x = '0;
        seg.start_y = '0;
        seg.end_x   = '0;
        seg.end_y   = '0;
        pix.ready   = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_degenerate();
        test_shallow();
        test_steep();
        wait_drained();
        test_random_segments();
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("** antialiased_line_rasterizer: PASSED **");
        else
            $display("** antialiased_line_rasterizer: FAILED **");
        $finish;
    end

endmodule
